// File: src/chained_hash_map_engine_macros.svh
// ---------------------------------------------------------------------------
// chained_hash_map_engine_macros.svh
// Assertion macros for the hash map engine.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`define CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CHM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CHM_ASSERT_IMP(label, clk, rst_n, a, c)
`define CHM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: src/chm_pkg.sv
// ---------------------------------------------------------------------------
// chm_pkg
// Types, codes and defaults for the hash map engine.
// ---------------------------------------------------------------------------
package chm_pkg;
    localparam int BUCKETS_DEF = 1024;
    localparam int NODES_DEF   = 1024;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_NEW    = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [15:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_value;
        logic [10:0] entry_count;
    } rsp_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load_req;    // latch request, read bucket head, reset prev and step count
        logic clear_step;  // write null into bucket at clear index
        logic rd_node;     // read node at cur
        logic step;        // advance prev/cur along chain
        logic ins_take;    // read free node link, point cur back at bucket head
        logic ins_write;   // write new node and bucket head
        logic del_unlink;  // relink predecessor or bucket head
        logic del_free;    // push node onto free list
        logic respond;     // drive result strobe
        logic [1:0] status;
        logic use_val;     // result_value: 1 node value, 0 see status
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic cur_null;
        logic key_hit;
        logic steps_done;
        logic free_avail;
        logic fresh_avail;
        logic [1:0] op;
    } sts_t;
endpackage

// File: src/chm_ram.sv
// ---------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM (one write port, one read port) with registered read.
// ---------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/chm_datapath.sv
// ---------------------------------------------------------------------------
// chm_datapath
// Memories, chain pointers and allocation state for the hash map.
// ---------------------------------------------------------------------------
module chm_datapath #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
    parameter int NODES   = chm_pkg::NODES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  chm_pkg::req_t req,
    input  chm_pkg::cmd_t cmd,
    output chm_pkg::sts_t sts,
    output chm_pkg::rsp_t rsp
);
    import chm_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(NODES + 1);   // holds the null index
    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [NW-1:0] NULL_IDX = NW'(NODES);

    req_t          req_reg;
    logic [BW-1:0] bkt_reg, clr_reg;
    logic          clr_done_reg;
    logic [NW-1:0] cur_reg, prev_reg, free_reg, fresh_reg, cnt_reg, steps_reg;
    logic [NW-1:0] ins_node;
    logic [NW-1:0] cnt_out;

    // memory ports
    logic          b_we;
    logic [BW-1:0] b_wa, b_ra;
    logic [NW-1:0] b_wd, b_rd;
    logic          k_we, v_we, l_we;
    logic [AW-1:0] n_ra, l_wa;
    logic [NW-1:0] l_wd, l_rd;
    logic [31:0]   k_rd;
    logic [15:0]   v_rd;
    logic          head_vld_reg, node_vld_reg;

    logic [BW-1:0] new_bkt;
    assign new_bkt = BW'(req.key % 32'(BUCKETS));

    chm_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_heads (
        .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
    chm_ram #(.WIDTH(32), .DEPTH(NODES)) u_keys (
        .clk(clk), .we(k_we), .waddr(AW'(ins_node)), .wdata(req_reg.key),
        .raddr(n_ra), .rdata(k_rd));
    chm_ram #(.WIDTH(16), .DEPTH(NODES)) u_vals (
        .clk(clk), .we(v_we), .waddr(AW'(ins_node)), .wdata(req_reg.value),
        .raddr(n_ra), .rdata(v_rd));
    chm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_links (
        .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(n_ra), .rdata(l_rd));

    // live pointer: bucket head right after load, else link after a node read
    logic [NW-1:0] cur_live;
    assign cur_live = head_vld_reg ? b_rd : cur_reg;
    assign ins_node = (free_reg != NULL_IDX) ? free_reg : fresh_reg;

    always_comb
    begin
        b_we = 1'b0; b_wa = bkt_reg; b_wd = NULL_IDX; b_ra = new_bkt;
        k_we = 1'b0; v_we = 1'b0; l_we = 1'b0;
        l_wa = AW'(cur_reg); l_wd = l_rd;
        n_ra = AW'(cur_live);
        if (cmd.ins_take)
        begin
            n_ra = AW'(free_reg);
        end
        if (cmd.clear_step)
        begin
            b_we = 1'b1; b_wa = clr_reg;
        end
        if (cmd.ins_write)
        begin
            k_we = 1'b1; v_we = 1'b1; l_we = 1'b1;
            l_wa = AW'(ins_node); l_wd = cur_reg;   // cur holds bucket head here
            b_we = 1'b1; b_wd = ins_node;
        end
        if (cmd.del_unlink)
        begin
            if (prev_reg != NULL_IDX)
            begin
                l_we = 1'b1; l_wa = AW'(prev_reg); l_wd = l_rd;
            end
            else
            begin
                b_we = 1'b1; b_wd = l_rd;
            end
        end
        if (cmd.del_free)
        begin
            l_we = 1'b1; l_wa = AW'(cur_reg); l_wd = free_reg;
        end
    end

    logic [NW-1:0] head_of_bkt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0; clr_done_reg <= 1'b0;
            free_reg <= NULL_IDX; fresh_reg <= '0; cnt_reg <= '0;
            head_vld_reg <= 1'b0; node_vld_reg <= 1'b0;
        end
        else
        begin
            head_vld_reg <= cmd.load_req;
            node_vld_reg <= cmd.rd_node;
            if (cmd.clear_step)
            begin
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    clr_done_reg <= 1'b1;
                end
                else
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
            end
            if (cmd.ins_write)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (free_reg != NULL_IDX)
                begin
                    free_reg <= l_rd;
                end
                else
                begin
                    fresh_reg <= fresh_reg + 1'b1;
                end
            end
            if (cmd.del_free)
            begin
                free_reg <= cur_reg;
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req; bkt_reg <= new_bkt;
            prev_reg <= NULL_IDX; steps_reg <= '0;
        end
        else if (cmd.step)
        begin
            prev_reg <= cur_reg; steps_reg <= steps_reg + 1'b1;
        end
        if (head_vld_reg)
        begin
            head_of_bkt_reg <= b_rd;
        end
        // insert links the new node in front of the bucket head
        if (cmd.ins_take)
        begin
            cur_reg <= head_vld_reg ? b_rd : head_of_bkt_reg;
        end
        else if (cmd.step)
        begin
            cur_reg <= l_rd;
        end
        else if (head_vld_reg)
        begin
            cur_reg <= b_rd;
        end
    end

    assign sts.clear_done  = clr_done_reg;
    assign sts.cur_null    = (cur_live >= NULL_IDX);
    assign sts.key_hit     = node_vld_reg && (k_rd == req_reg.key);
    assign sts.steps_done  = (steps_reg >= NULL_IDX);
    assign sts.free_avail  = (free_reg != NULL_IDX);
    assign sts.fresh_avail = (fresh_reg != NULL_IDX);
    assign sts.op          = req_reg.op;

    // count reported with the answer already includes this request
    always_comb
    begin
        if (cmd.ins_write)
        begin
            cnt_out = cnt_reg + 1'b1;
        end
        else if (cmd.del_unlink && cnt_reg != '0)
        begin
            cnt_out = cnt_reg - 1'b1;
        end
        else
        begin
            cnt_out = cnt_reg;
        end
    end

    always_comb
    begin
        rsp.status       = cmd.status;
        rsp.result_value = cmd.use_val ? v_rd : (cmd.status == ST_NEW ? req_reg.value : 16'd0);
        rsp.entry_count  = 11'(cnt_out);
    end
endmodule

// File: src/chm_ctrl.sv
// ---------------------------------------------------------------------------
// chm_ctrl
// Sequencer for clear, chain walk, insert and delete.
// ---------------------------------------------------------------------------
module chm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          strobe,
    input  chm_pkg::sts_t sts,
    output chm_pkg::cmd_t cmd
);
    import chm_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HEAD, S_NODE, S_CHECK, S_INS, S_FREE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_ABSENT;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done) state_next = S_IDLE;
                else cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD, S_NODE:
            begin
                // cur_live is valid; undefined op answers, else end of chain (or step limit) or read node
                if (sts.op != OP_FIND && sts.op != OP_INSERT && sts.op != OP_DELETE)
                begin
                    cmd.respond = 1'b1; state_next = S_IDLE;
                end
                else if (sts.cur_null || sts.steps_done)
                begin
                    if (sts.op == OP_INSERT)
                    begin
                        if (sts.free_avail || sts.fresh_avail)
                        begin
                            cmd.ins_take = 1'b1; state_next = S_INS;
                        end
                        else
                        begin
                            cmd.respond = 1'b1; cmd.status = ST_FULL; state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.respond = 1'b1; state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_node = 1'b1; state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.key_hit)
                begin
                    if (sts.op == OP_DELETE)
                    begin
                        cmd.del_unlink = 1'b1; state_next = S_FREE;
                    end
                    else
                    begin
                        cmd.respond = 1'b1; state_next = S_IDLE;
                    end
                    cmd.status  = ST_FOUND;
                    cmd.use_val = 1'b1;
                    cmd.respond = 1'b1;
                end
                else
                begin
                    cmd.step = 1'b1; state_next = S_NODE;
                end
            end
            S_INS:
            begin
                cmd.ins_write = 1'b1; cmd.respond = 1'b1; cmd.status = ST_NEW;
                state_next = S_IDLE;
            end
            S_FREE:
            begin
                cmd.del_free = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy   = busy_reg;
    assign strobe = cmd.respond;
endmodule

// File: src/chained_hash_map_engine.sv
// ---------------------------------------------------------------------------
// chained_hash_map_engine
// Key-to-data map with bucket chains over a fixed node pool.
// ---------------------------------------------------------------------------
// After reset the block clears the bucket head table, one bucket a cycle,
// with busy held high throughout. A request (find, insert, delete) is
// taken when start is high and busy low. The cycle after that fetches the
// bucket head; each node visited then takes a node memory read, then the
// key compare. A miss answers in the cycle after the last compare; a new
// insert answers in the cycle after that, when the node is allocated and
// linked. A hit at the chain head answers at the key compare of the first
// node. The answer appears for one cycle with valid; the receiver cannot
// stall it, so it must take the result that cycle. The next request may
// start the cycle after the answer (after a delete hit, not until the
// freed node is recorded).
// ---------------------------------------------------------------------------
module chained_hash_map_engine #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
    parameter int NODES   = chm_pkg::NODES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  chm_pkg::req_t req,
    output logic          valid,
    output chm_pkg::rsp_t rsp
);
    import chm_pkg::*;
    `include "chained_hash_map_engine_macros.svh"

    cmd_t cmd;
    sts_t sts;

    chm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .strobe(valid), .sts(sts), .cmd(cmd));

    chm_datapath #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd), .sts(sts), .rsp(rsp));

    // accepted request keeps the block busy on the next cycle
    `CHM_ASSERT_NXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
    // a result only comes while a request is in flight
    `CHM_ASSERT_IMP(a_valid_busy, clk, rst_n, valid, busy)
    // an insert never pushes the count past the pool size
    `CHM_ASSERT_IMP(a_new_not_full, clk, rst_n, valid && rsp.status == ST_NEW,
        rsp.entry_count <= 11'(NODES))
endmodule

// File: tb/sv/chained_hash_map_engine_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_hash_map_engine_checker
// Watches requests and answers of the hash map engine, keeps its own copy
// of the map and compares every answer field by field, in order.
// ---------------------------------------------------------------------------
module chained_hash_map_engine_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  chm_pkg::req_t req,
    input  logic          valid,
    input  chm_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending
);
    import chm_pkg::*;

    localparam int          NB   = BUCKETS_DEF;
    localparam int          NN   = NODES_DEF;
    localparam logic [10:0] NONE = 11'(NN);

    logic [10:0] head_of [NB];
    logic [31:0] key_of  [NN];
    logic [15:0] data_of [NN];
    logic [10:0] next_of [NN];
    logic [10:0] free_head;
    logic [10:0] fresh_next;
    logic [10:0] held;
    rsp_t        answers_due[$];

    // Apply one request to the map copy and return the answer it owes.
    function automatic rsp_t map_apply(req_t r);
        rsp_t        a;
        logic [9:0]  b;
        logic [10:0] n, p, t;
        int          steps;
        b = r.key[9:0];
        a.status = ST_ABSENT;
        a.result_value = '0;
        if (r.op != OP_UNUSED)
        begin
            n = head_of[b];
            p = NONE;
            steps = 0;
            while (n != NONE && steps < NN && key_of[n] != r.key)
            begin
                p = n;
                n = next_of[n];
                steps++;
            end
            if (steps >= NN)
                n = NONE;
            if (n != NONE)
            begin
                a.status = ST_FOUND;
                a.result_value = data_of[n];
                if (r.op == OP_DELETE)
                begin
                    if (p != NONE)
                        next_of[p] = next_of[n];
                    else
                        head_of[b] = next_of[n];
                    next_of[n] = free_head;
                    free_head = n;
                    if (held != 0)
                        held--;
                end
            end
            else if (r.op == OP_INSERT)
            begin
                t = NONE;
                if (free_head != NONE)
                begin
                    t = free_head;
                    free_head = next_of[t];
                end
                else if (fresh_next != NONE)
                begin
                    t = fresh_next;
                    fresh_next++;
                end
                if (t != NONE)
                begin
                    key_of[t] = r.key;
                    data_of[t] = r.value;
                    next_of[t] = head_of[b];
                    head_of[b] = t;
                    held++;
                    a.status = ST_NEW;
                    a.result_value = r.value;
                end
                else
                    a.status = ST_FULL;
            end
        end
        a.entry_count = held;
        return a;
    endfunction

    assign pending = answers_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        if (!rst_n)
        begin
            foreach (head_of[i]) head_of[i] = NONE;
            free_head = NONE;
            fresh_next = '0;
            held = '0;
            answers_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (valid)
            begin
                if (answers_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("answer with none due: %p", rsp);
                end
                else
                begin
                    e = answers_due.pop_front();
                    if (rsp.status !== e.status || rsp.result_value !== e.result_value
                        || rsp.entry_count !== e.entry_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", e, rsp);
                    end
                end
            end
            if (start && !busy)
                answers_due.push_back(map_apply(req));
        end
    end
endmodule

// File: tb/sv/chained_hash_map_engine_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_hash_map_engine_test
// Drives find/insert/delete (and undefined-op) requests into the hash map
// engine: a directed opening, randomized traffic over colliding keys under
// three sender idle profiles, then a fill of the whole node pool. The checker judges answers.
// ---------------------------------------------------------------------------
module chained_hash_map_engine_test;
    import chm_pkg::*;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    req_t  req = '0;
    logic  valid;
    rsp_t  rsp;
    int    fail_count;
    int    pending;
    int    idle_pct = 0;
    logic [31:0] key_pool[64];

    always #2 clk = ~clk;

    chained_hash_map_engine dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .valid(valid), .rsp(rsp)
    );

    chained_hash_map_engine_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .valid(valid), .rsp(rsp), .fail_count(fail_count), .pending(pending)
    );

    // Issue one request; start stays high across back-to-back requests so it
    // only ever gets one assignment per edge.
    task automatic send_request(logic [1:0] op, logic [31:0] key, logic [15:0] val);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 12)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= '{op: op, key: key, value: val};
        do
            @(posedge clk);
        while (busy);
    endtask

    // Mostly keys from a small pool that crowds a few buckets, so chains grow
    // and deletes hit heads, middles and tails; some fully random keys.
    function automatic logic [31:0] pick_key();
        if ($urandom_range(9) == 0)
            return $urandom;
        return key_pool[$urandom_range(63)];
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 40) return OP_INSERT;
        if (r < 70) return OP_FIND;
        if (r < 95) return OP_DELETE;
        return OP_UNUSED;
    endfunction

    initial
    begin
        foreach (key_pool[i])
            key_pool[i] = {22'($urandom_range(32'h3F_FFFF)), 10'($urandom_range(7) * 97)};
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening
        send_request(OP_FIND,   32'h0,         16'h1234);  // miss on empty map
        send_request(OP_DELETE, 32'h0,         16'h0);     // delete miss
        send_request(OP_INSERT, 32'h0,         16'h0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_INSERT, 32'h0,         16'h5555);  // already present
        send_request(OP_INSERT, 32'h400,       16'hAAAA);  // same bucket as 0
        send_request(OP_INSERT, 32'h800,       16'h0F0F);  // chain of three
        send_request(OP_FIND,   32'h0,         16'h0);     // tail of chain
        send_request(OP_FIND,   32'hFFFF_FFFF, 16'h0);
        send_request(OP_DELETE, 32'h400,       16'h0);     // middle of chain
        send_request(OP_FIND,   32'h400,       16'h0);
        send_request(OP_FIND,   32'hC00,       16'h0);     // same bucket, absent
        send_request(OP_UNUSED, 32'h0,         16'hFFFF);  // undefined op
        send_request(OP_DELETE, 32'h800,       16'h0);     // chain head
        send_request(OP_INSERT, 32'h400,       16'h7777);  // reuses a freed node
        send_request(OP_DELETE, 32'h0,         16'h0);

        // random traffic under three idle profiles
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 35 : (ph == 1) ? 68 : 0;
            repeat (285)
                send_request(pick_op(), pick_key(), 16'($urandom));
        end

        // fill the pool with distinct keys, run into pool-full, then free some
        idle_pct = 10;
        for (int i = 1; i <= 1040; i++)
            send_request(OP_INSERT, {20'(i), 12'($urandom_range(4095))}, 16'($urandom));
        repeat (40)
            send_request(pick_op(), pick_key(), 16'($urandom));
        start <= 1'b0;

        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/chm_pkg.sv
src/chm_ram.sv
src/chm_datapath.sv
src/chm_ctrl.sv
src/chained_hash_map_engine.sv
tb/sv/chained_hash_map_engine_checker.sv
tb/sv/chained_hash_map_engine_test.sv
